FILE: hdl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types, codes and widths of the touch sample conditioner
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int POS_W           = 12;
    localparam int TICK_W          = 32;
    localparam int THRESH_W        = 13;
    localparam int ADC_MAX_DEFAULT = 4095;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // input word: now_ticks, z1, z2, y samples, x samples
    localparam int IN_DATA_W  = TICK_W + 8 * SAMPLE_W;
    localparam int OUT_DATA_W = 2 * POS_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROTATION    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_THR = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_THR   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF     = CFG_INDEX_W'(3);

    localparam logic [THRESH_W-1:0] RELEASE_THR_RESET = THRESH_W'(75);
    localparam logic [THRESH_W-1:0] PRESS_THR_RESET   = THRESH_W'(400);
    localparam logic [TICK_W-1:0]   HOLDOFF_RESET     = TICK_W'(3000);

    typedef enum logic {
        OP_PEN  = 1'b0,
        OP_POLL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_MOVE = 2'd1,
        EV_UP   = 2'd2
    } ev_t;

endpackage

FILE: hdl/tsc_pair_mean.sv
// ----------------------------------------------------------------------------
// tsc_pair_mean
// floored mean of the closest pair out of three samples
// ----------------------------------------------------------------------------
module tsc_pair_mean
    import tsc_pkg::*;
(
    input  logic [SAMPLE_W-1:0] first,
    input  logic [SAMPLE_W-1:0] second,
    input  logic [SAMPLE_W-1:0] third,
    output logic [SAMPLE_W-1:0] mean
);

    logic [SAMPLE_W-1:0] d_ab;
    logic [SAMPLE_W-1:0] d_ac;
    logic [SAMPLE_W-1:0] d_bc;
    logic [SAMPLE_W:0]   sum_ab;
    logic [SAMPLE_W:0]   sum_ac;
    logic [SAMPLE_W:0]   sum_bc;

    assign d_ab = (first > second) ? first - second : second - first;
    assign d_ac = (first > third)  ? first - third  : third - first;
    assign d_bc = (second > third) ? second - third : third - second;

    assign sum_ab = {1'b0, first}  + {1'b0, second};
    assign sum_ac = {1'b0, first}  + {1'b0, third};
    assign sum_bc = {1'b0, second} + {1'b0, third};

    // ties go to the earlier pair
    always_comb
    begin
        priority if (d_ab <= d_ac && d_ab <= d_bc)
        begin
            mean = sum_ab[SAMPLE_W:1];
        end
        else if (d_ac <= d_ab && d_ac <= d_bc)
        begin
            mean = sum_ac[SAMPLE_W:1];
        end
        else
        begin
            mean = sum_bc[SAMPLE_W:1];
        end
    end

endmodule

FILE: hdl/touch_sample_conditioner_top.sv
// ----------------------------------------------------------------------------
// touch_sample_conditioner_top
// turns resistive touch panel samples into finger down, move and up events
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle unless the result side
// stalls, and returns its event, if any, from the input register through
// the result register. All pressure, closest-pair and rotation logic sits in
// a single combinational pass between those two registers, and the armed,
// finger and press-time state is updated in that same pass, so back-to-back
// polls see each other's effects. A result that waits on m_axis_tready
// stalls the input side only once both registers are full. Configuration
// writes are taken in every cycle and should be made while the block is idle.
module touch_sample_conditioner_top
    import tsc_pkg::*;
#(
    parameter int ADC_MAX = ADC_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // now_ticks[31:0], pressure_one, pressure_two, y_first, y_second, y_third,
    // x_first, x_second, x_third (12 bits each, from bit 32 up)
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pos_x[11:0], pos_y[23:12]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // touch_event
    output logic [1:0]             m_axis_tuser,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // signed pressure z1 + ADC_MAX - z2 never overflows this width
    localparam int PRESS_W = $clog2(ADC_MAX + (1 << SAMPLE_W)) + 1;
    localparam logic [POS_W-1:0] ADC_LOW = POS_W'(ADC_MAX);

    // configuration
    rot_t                rotation_reg;
    logic [THRESH_W-1:0] release_thr_reg;
    logic [THRESH_W-1:0] press_thr_reg;
    logic [TICK_W-1:0]   holdoff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg    <= ROT_0;
            release_thr_reg <= RELEASE_THR_RESET;
            press_thr_reg   <= PRESS_THR_RESET;
            holdoff_reg     <= HOLDOFF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROTATION:    rotation_reg    <= rot_t'(cfg_data[1:0]);
                CFG_RELEASE_THR: release_thr_reg <= cfg_data[THRESH_W-1:0];
                CFG_PRESS_THR:   press_thr_reg   <= cfg_data[THRESH_W-1:0];
                CFG_HOLDOFF:     holdoff_reg     <= cfg_data[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // input register
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    op_t                  in_op_reg;
    logic                 advance;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_op_reg   <= op_t'(s_axis_tuser);
        end
    end

    // field split
    logic [TICK_W-1:0]   now_ticks;
    logic [SAMPLE_W-1:0] pressure_one;
    logic [SAMPLE_W-1:0] pressure_two;
    logic [SAMPLE_W-1:0] y_first;
    logic [SAMPLE_W-1:0] y_second;
    logic [SAMPLE_W-1:0] y_third;
    logic [SAMPLE_W-1:0] x_first;
    logic [SAMPLE_W-1:0] x_second;
    logic [SAMPLE_W-1:0] x_third;

    assign now_ticks    = in_data_reg[TICK_W-1:0];
    assign pressure_one = in_data_reg[TICK_W + 0*SAMPLE_W +: SAMPLE_W];
    assign pressure_two = in_data_reg[TICK_W + 1*SAMPLE_W +: SAMPLE_W];
    assign y_first      = in_data_reg[TICK_W + 2*SAMPLE_W +: SAMPLE_W];
    assign y_second     = in_data_reg[TICK_W + 3*SAMPLE_W +: SAMPLE_W];
    assign y_third      = in_data_reg[TICK_W + 4*SAMPLE_W +: SAMPLE_W];
    assign x_first      = in_data_reg[TICK_W + 5*SAMPLE_W +: SAMPLE_W];
    assign x_second     = in_data_reg[TICK_W + 6*SAMPLE_W +: SAMPLE_W];
    assign x_third      = in_data_reg[TICK_W + 7*SAMPLE_W +: SAMPLE_W];

    logic [SAMPLE_W-1:0] filt_y;
    logic [SAMPLE_W-1:0] filt_x;

    tsc_pair_mean u_mean_y
    (
        .first  (y_first),
        .second (y_second),
        .third  (y_third),
        .mean   (filt_y)
    );

    tsc_pair_mean u_mean_x
    (
        .first  (x_first),
        .second (x_second),
        .third  (x_third),
        .mean   (filt_x)
    );

    // touch state
    logic              armed_reg;
    logic              armed_next;
    logic              finger_reg;
    logic              finger_next;
    logic [TICK_W-1:0] last_press_reg;
    logic [TICK_W-1:0] last_press_next;

    // pressure and thresholds
    logic signed [PRESS_W-1:0] pressure;
    logic signed [PRESS_W-1:0] release_ext;
    logic signed [PRESS_W-1:0] press_ext;
    logic                      below_release;
    logic                      above_press;
    logic                      holdoff_done;
    logic [TICK_W-1:0]         elapsed;

    assign pressure = $signed(PRESS_W'(pressure_one) + PRESS_W'(ADC_MAX)
                              - PRESS_W'(pressure_two));
    assign release_ext   = $signed(PRESS_W'(release_thr_reg));
    assign press_ext     = $signed(PRESS_W'(press_thr_reg));
    assign below_release = pressure < release_ext;
    assign above_press   = pressure >= press_ext;

    // wrapping tick difference
    assign elapsed      = now_ticks - last_press_reg;
    assign holdoff_done = elapsed >= holdoff_reg;

    // rotation
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;

    always_comb
    begin
        unique case (rotation_reg)
            ROT_0:
            begin
                pos_x = ADC_LOW - filt_x;
                pos_y = filt_y;
            end
            ROT_90:
            begin
                pos_x = filt_y;
                pos_y = filt_x;
            end
            ROT_180:
            begin
                pos_x = filt_x;
                pos_y = ADC_LOW - filt_y;
            end
            default:
            begin
                pos_x = ADC_LOW - filt_y;
                pos_y = ADC_LOW - filt_x;
            end
        endcase
    end

    // state and result
    logic              res_valid;
    ev_t               res_event;
    logic [POS_W-1:0]  res_x;
    logic [POS_W-1:0]  res_y;
    logic              step;

    assign step = in_valid_reg && advance;

    always_comb
    begin
        armed_next      = armed_reg;
        finger_next     = finger_reg;
        last_press_next = last_press_reg;
        res_valid       = 1'b0;
        res_event       = EV_UP;
        res_x           = '0;
        res_y           = '0;
        if (in_op_reg == OP_PEN)
        begin
            armed_next = 1'b1;
        end
        else if (armed_reg && holdoff_done)
        begin
            // release test comes first when thresholds overlap
            if (below_release)
            begin
                armed_next  = 1'b0;
                finger_next = 1'b0;
                res_valid   = finger_reg;
            end
            else if (above_press)
            begin
                last_press_next = now_ticks;
                finger_next     = 1'b1;
                res_valid       = 1'b1;
                res_event       = finger_reg ? EV_MOVE : EV_DOWN;
                res_x           = pos_x;
                res_y           = pos_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            finger_reg     <= 1'b0;
            last_press_reg <= '0;
        end
        else if (step)
        begin
            armed_reg      <= armed_next;
            finger_reg     <= finger_next;
            last_press_reg <= last_press_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (advance)
        begin
            m_axis_tvalid <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            m_axis_tdata <= {res_y, res_x};
            m_axis_tuser <= res_event;
        end
    end

endmodule

FILE: hdl/tsc_checker.sv
// ----------------------------------------------------------------------------
// tsc_checker
// port-level checks of the touch sample conditioner, bound to the top level
// ----------------------------------------------------------------------------
module tsc_checker
    import tsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    // finger state as seen from delivered words
    logic seen_down_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_down_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            seen_down_reg <= (m_axis_tuser != EV_UP);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == EV_UP |-> m_axis_tdata == '0)
        else $error("finger up word carries a position");

    a_event_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == EV_DOWN && !seen_down_reg) ||
            (m_axis_tuser == EV_MOVE && seen_down_reg) ||
            (m_axis_tuser == EV_UP && seen_down_reg))
        else $error("touch event out of order");

    // a new result needs a matching input word accepted through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result word without a matching input word");

endmodule

bind touch_sample_conditioner_top tsc_checker u_tsc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: sim/touch_sample_conditioner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_conditioner_top_tb
// self-checking bench for the touch sample conditioner: pen and poll words
// go in on the input stream, and every event that comes out is compared
// field by field with an event predicted in the bench from the same words
// ----------------------------------------------------------------------------
module touch_sample_conditioner_top_tb;
    import tsc_pkg::*;

    localparam int ADC_MAX       = ADC_MAX_DEFAULT;
    localparam int PRESSURE_TOP  = 2 * ADC_MAX;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;

    // packed so that it lines up with s_axis_tdata, now_ticks in the low bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] x_third;
        logic [SAMPLE_W-1:0] x_second;
        logic [SAMPLE_W-1:0] x_first;
        logic [SAMPLE_W-1:0] y_third;
        logic [SAMPLE_W-1:0] y_second;
        logic [SAMPLE_W-1:0] y_first;
        logic [SAMPLE_W-1:0] pressure_two;
        logic [SAMPLE_W-1:0] pressure_one;
        logic [TICK_W-1:0]   now_ticks;
    } sample_set_t;

    typedef struct packed {
        op_t         op;
        sample_set_t data;
    } touch_item_t;

    typedef struct packed {
        ev_t             ev;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
    } touch_event_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    touch_sample_conditioner_top #(.ADC_MAX(ADC_MAX)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // bench copy of the configuration and the touch state
    logic [1:0]          rot_setting   = 2'd0;
    logic [THRESH_W-1:0] release_level = RELEASE_THR_RESET;
    logic [THRESH_W-1:0] press_level   = PRESS_THR_RESET;
    logic [TICK_W-1:0]   holdoff_span  = HOLDOFF_RESET;
    logic                pen_armed      = 1'b0;
    logic                finger_is_down = 1'b0;
    logic [TICK_W-1:0]   last_press_at  = '0;

    touch_item_t  pending_words[$];
    touch_event_t awaited_events[$];

    int  issued_count = 0;
    int  taken_count  = 0;
    int  poll_count   = 0;
    int  cfg_count    = 0;
    int  down_count   = 0;
    int  move_count   = 0;
    int  up_count     = 0;
    int  errors       = 0;
    int  quiet_cycles = 0;
    int  send_gap     = 0;
    int  recv_gap     = 0;
    bit  calm         = 1'b0;
    bit  word_taken   = 1'b0;
    logic [TICK_W-1:0] tick_now = '0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [POS_W-1:0] pair_mean(logic [SAMPLE_W-1:0] a,
                                                   logic [SAMPLE_W-1:0] b,
                                                   logic [SAMPLE_W-1:0] c);
        int ia, ib, ic, dab, dac, dbc;
        ia = a;
        ib = b;
        ic = c;
        dab = (ia > ib) ? ia - ib : ib - ia;
        dac = (ia > ic) ? ia - ic : ic - ia;
        dbc = (ib > ic) ? ib - ic : ic - ib;
        // ties go to the earlier pair
        if (dab <= dac && dab <= dbc) return POS_W'((ia + ib) >> 1);
        if (dac <= dbc) return POS_W'((ia + ic) >> 1);
        return POS_W'((ib + ic) >> 1);
    endfunction

    task automatic predict_event(input touch_item_t it);
        int pressure;
        logic [POS_W-1:0] fy, fx, px, py;
        touch_event_t e;
        if (it.op == OP_PEN) begin
            pen_armed = 1'b1;
        end
        else if (pen_armed && (it.data.now_ticks - last_press_at) >= holdoff_span) begin
            pressure = int'(it.data.pressure_one) + ADC_MAX - int'(it.data.pressure_two);
            fy = pair_mean(it.data.y_first, it.data.y_second, it.data.y_third);
            fx = pair_mean(it.data.x_first, it.data.x_second, it.data.x_third);
            case (rot_t'(rot_setting))
                ROT_0:   begin px = POS_W'(ADC_MAX - int'(fx)); py = fy; end
                ROT_90:  begin px = fy; py = fx; end
                ROT_180: begin px = fx; py = POS_W'(ADC_MAX - int'(fy)); end
                default: begin
                    px = POS_W'(ADC_MAX - int'(fy));
                    py = POS_W'(ADC_MAX - int'(fx));
                end
            endcase
            if (pressure < int'(release_level)) begin
                pen_armed = 1'b0;
                if (finger_is_down) begin
                    finger_is_down = 1'b0;
                    e.ev = EV_UP;
                    e.pos_x = '0;
                    e.pos_y = '0;
                    awaited_events.push_back(e);
                end
            end
            else if (pressure >= int'(press_level)) begin
                last_press_at = it.data.now_ticks;
                e.ev = finger_is_down ? EV_MOVE : EV_DOWN;
                e.pos_x = px;
                e.pos_y = py;
                finger_is_down = 1'b1;
                awaited_events.push_back(e);
            end
        end
    endtask

    // sender
    always @(negedge clk) begin
        touch_item_t next_word;
        if (rst_n && (!s_axis_tvalid || word_taken)) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_words.size() > 0) begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_word.data;
                s_axis_tuser  <= next_word.op;
                send_gap <= pick_gap();
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap > 0) begin
            m_axis_tready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // monitor: predicts on every accepted input word, checks every event
    always @(posedge clk) begin
        touch_item_t  seen_word;
        touch_event_t want;
        word_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                quiet_cycles = 0;
                cfg_count++;
                case (cfg_index)
                    CFG_ROTATION:    rot_setting   = cfg_data[1:0];
                    CFG_RELEASE_THR: release_level = cfg_data[THRESH_W-1:0];
                    CFG_PRESS_THR:   press_level   = cfg_data[THRESH_W-1:0];
                    CFG_HOLDOFF:     holdoff_span  = cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                taken_count++;
                seen_word.op   = op_t'(s_axis_tuser);
                seen_word.data = s_axis_tdata;
                if (seen_word.op == OP_POLL) poll_count++;
                predict_event(seen_word);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                case (m_axis_tuser)
                    EV_DOWN: down_count++;
                    EV_MOVE: move_count++;
                    default: up_count++;
                endcase
                if (awaited_events.size() == 0) begin
                    errors++;
                    $display("%0t: event with none expected: tuser %0d tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                end
                else begin
                    want = awaited_events.pop_front();
                    if (m_axis_tuser != want.ev) begin
                        errors++;
                        $display("%0t: touch_event expected %0d actual %0d",
                                 $time, want.ev, m_axis_tuser);
                    end
                    if (m_axis_tdata[POS_W-1:0] != want.pos_x) begin
                        errors++;
                        $display("%0t: pos_x expected %0d actual %0d",
                                 $time, want.pos_x, m_axis_tdata[POS_W-1:0]);
                    end
                    if (m_axis_tdata[2*POS_W-1:POS_W] != want.pos_y) begin
                        errors++;
                        $display("%0t: pos_y expected %0d actual %0d",
                                 $time, want.pos_y, m_axis_tdata[2*POS_W-1:POS_W]);
                    end
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_word(input touch_item_t it);
        pending_words.push_back(it);
        issued_count++;
    endtask

    task automatic push_pen();
        touch_item_t it;
        it.op = OP_PEN;
        it.data = {$urandom, $urandom, $urandom, $urandom};
        push_word(it);
    endtask

    function automatic logic [SAMPLE_W-1:0] near_sample(int base);
        int v;
        v = base + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > ADC_MAX) v = ADC_MAX;
        return SAMPLE_W'(v);
    endfunction

    // poll word whose z1 + ADC_MAX - z2 equals the wanted pressure
    function automatic touch_item_t poll_word(logic [TICK_W-1:0] ticks, int pressure);
        touch_item_t it;
        int by, bx, d;
        it.op = OP_POLL;
        it.data.now_ticks = ticks;
        by = $urandom_range(0, ADC_MAX);
        bx = $urandom_range(0, ADC_MAX);
        if ($urandom_range(0, 3) == 0) begin
            it.data.y_first  = SAMPLE_W'($urandom_range(0, ADC_MAX));
            it.data.y_second = SAMPLE_W'($urandom_range(0, ADC_MAX));
            it.data.y_third  = SAMPLE_W'($urandom_range(0, ADC_MAX));
            it.data.x_first  = SAMPLE_W'($urandom_range(0, ADC_MAX));
            it.data.x_second = SAMPLE_W'($urandom_range(0, ADC_MAX));
            it.data.x_third  = SAMPLE_W'($urandom_range(0, ADC_MAX));
        end
        else begin
            it.data.y_first  = near_sample(by);
            it.data.y_second = near_sample(by);
            it.data.y_third  = near_sample(by);
            it.data.x_first  = near_sample(bx);
            it.data.x_second = near_sample(bx);
            it.data.x_third  = near_sample(bx);
        end
        d = pressure - ADC_MAX;
        if (d >= 0) begin
            it.data.pressure_two = SAMPLE_W'($urandom_range(0, ADC_MAX - d));
            it.data.pressure_one = SAMPLE_W'(int'(it.data.pressure_two) + d);
        end
        else begin
            it.data.pressure_one = SAMPLE_W'($urandom_range(0, ADC_MAX + d));
            it.data.pressure_two = SAMPLE_W'(int'(it.data.pressure_one) - d);
        end
        return it;
    endfunction

    task automatic push_noise();
        touch_item_t it;
        it.op = op_t'($urandom_range(0, 1));
        it.data = {$urandom, $urandom, $urandom, $urandom};
        push_word(it);
    endtask

    function automatic logic [TICK_W-1:0] next_tick();
        logic [TICK_W-1:0] extra;
        extra = ($urandom_range(0, 3) == 0) ? TICK_W'($urandom_range(1, 50)) : '0;
        return tick_now + holdoff_span + extra;
    endfunction

    // usually arm, a few presses, maybe a poll between the thresholds, then release
    task automatic touch_burst(output int made);
        int n, top;
        made = 0;
        if ($urandom_range(0, 5) != 0) begin
            push_pen();
            made++;
        end
        n = $urandom_range(1, 6);
        top = (int'(press_level) > PRESSURE_TOP) ? PRESSURE_TOP : int'(press_level);
        for (int i = 0; i < n; i++) begin
            if (holdoff_span > 0 && $urandom_range(0, 9) == 0) begin
                push_word(poll_word(tick_now + $urandom_range(0, holdoff_span - 1),
                                    $urandom_range(top, PRESSURE_TOP)));
                made++;
            end
            tick_now = next_tick();
            if (release_level < press_level && $urandom_range(0, 7) == 0)
                push_word(poll_word(tick_now, $urandom_range(release_level, press_level - 1)));
            else
                push_word(poll_word(tick_now, $urandom_range(top, PRESSURE_TOP)));
            made++;
        end
        tick_now = next_tick();
        if (release_level > 0)
            push_word(poll_word(tick_now, $urandom_range(0, int'(release_level) - 1)));
        else
            push_word(poll_word(tick_now, $urandom_range(0, PRESSURE_TOP)));
        made++;
    endtask

    // waits until every issued word is taken and every awaited event is back
    task automatic settle();
        while (taken_count != issued_count || awaited_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int seen;
        seen = cfg_count;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        while (cfg_count == seen) @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int rot, input int rel, input int prs,
                             input logic [TICK_W-1:0] hold);
        write_reg(CFG_ROTATION, CFG_DATA_W'(rot));
        write_reg(CFG_RELEASE_THR, CFG_DATA_W'(rel));
        write_reg(CFG_PRESS_THR, CFG_DATA_W'(prs));
        write_reg(CFG_HOLDOFF, hold);
    endtask

    task automatic random_phase(input int quota);
        int made, got;
        bit paused;
        made = 0;
        paused = 1'b0;
        while (made < quota) begin
            if ($urandom_range(0, 4) == 0) begin
                push_noise();
                made++;
            end
            else begin
                touch_burst(got);
                made += got;
            end
            if (!paused && made >= quota / 2) begin
                settle();
                paused = 1'b1;
            end
        end
        settle();
    endtask

    initial begin
        touch_item_t it;
        int rel, prs;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset settings
        push_word(poll_word(32'd5000, PRESSURE_TOP));        // not armed
        push_pen();
        push_word(poll_word(32'd100, PRESSURE_TOP));         // inside hold-off after reset
        push_pen();                                          // already armed
        it = poll_word(32'd3000, PRESSURE_TOP);
        it.data.y_first = '0; it.data.y_second = '0; it.data.y_third = '0;
        it.data.x_first = '0; it.data.x_second = '0; it.data.x_third = '0;
        push_word(it);                                       // finger down, extremes
        push_word(poll_word(32'd3001, PRESSURE_TOP));        // hold-off after press
        it = poll_word(32'd6000, 400);                       // exactly press level
        it.data.y_first = 12'd10; it.data.y_second = 12'd20; it.data.y_third = 12'd30;
        it.data.x_first = 12'd10; it.data.x_second = 12'd30; it.data.x_third = 12'd20;
        push_word(it);                                       // closest pair ties
        push_word(poll_word(32'd9000, 399));                 // between thresholds
        push_word(poll_word(32'd12000, 75));                 // exactly release level
        push_word(poll_word(32'd15000, 74));                 // finger up
        push_word(poll_word(32'd18000, PRESSURE_TOP));       // disarmed
        push_pen();
        push_word(poll_word(32'd21000, 0));                  // up while already up
        push_pen();
        it = poll_word(32'd24000, PRESSURE_TOP);
        it.data.y_first = '1; it.data.y_second = '1; it.data.y_third = '1;
        it.data.x_first = '1; it.data.x_second = '0; it.data.x_third = '1;
        push_word(it);
        it = poll_word(32'd27000, PRESSURE_TOP);
        it.data.x_first = 12'd0; it.data.x_second = '1; it.data.x_third = 12'd2048;
        it.data.y_first = 12'd7; it.data.y_second = 12'd7; it.data.y_third = 12'd7;
        push_word(it);
        push_word(poll_word(32'd30000, 4095));
        push_pen();
        push_word(poll_word(32'd33000, 10));
        tick_now = 32'd33000;
        settle();

        for (int phase = 0; phase < 8; phase++) begin
            rel = $urandom_range(0, 3000);
            prs = $urandom_range(rel, 6000);
            calm = (phase == 7);
            case (phase)
                0: configure(0, 75, 400, 32'd0);
                1: configure(1, rel, prs, TICK_W'($urandom_range(1, 500)));
                2: configure(2, 0, PRESSURE_TOP, 32'd10);
                3: configure(3, PRESSURE_TOP, 0, 32'd1);
                4: configure(1, 3000, 1000, TICK_W'($urandom_range(0, 200)));
                5: configure(2, rel, prs, 32'hFFFF_FFFF);
                6: begin
                    configure(3, rel, prs, 32'd100);
                    tick_now = 32'hFFFF_FFC0;                // presses across the wrap
                end
                default: configure(0, RELEASE_THR_RESET, PRESS_THR_RESET, 32'd3000);
            endcase
            random_phase(50);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_events.size() != 0) begin
            errors++;
            $display("%0t: %0d events never arrived", $time, awaited_events.size());
        end
        $display("ran %0d input words (%0d polls) over 9 register settings, all rotations",
                 taken_count, poll_count);
        $display("events seen: %0d down, %0d move, %0d up, %0d mismatches",
                 down_count, move_count, up_count, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
